[sv/assert_macros.svh]
// Assertion macros included by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// Condition that must hold on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

`endif

[sv/hsv2rgb_pkg.sv]
// Types and constants for the HSV to RGB pixel unit.
package hsv2rgb_pkg;

   localparam int unsigned HUE_W   = 16;
   localparam int unsigned UNIT_W  = 13;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned LEVEL_W = 41;  // levels in units of 2^-40, 0..2^40
   localparam int unsigned PROD_W  = 48;  // level * 255 plus rounding half
   localparam int unsigned LATENCY = 6;

   localparam logic [UNIT_W-1:0] FULL_ONE = 13'd4096;

   typedef struct packed {
      logic [HUE_W-1:0]  hue;
      logic [UNIT_W-1:0] saturation;
      logic [UNIT_W-1:0] brightness;
   } pixel_in_type;

   typedef struct packed {
      logic [BYTE_W-1:0] red;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] blue;
   } pixel_out_type;

endpackage

[sv/hsv_to_rgb_pixel_unit.sv]
// Top level of the HSV to RGB pixel unit: six-stage conversion pipeline.
//
// Usage:
//   An item (hue, saturation, brightness) is taken from req_pixel at each rising
//   edge where start is high and busy is low. busy is always low: the pipeline
//   has no stall point, so an item may be given on every cycle.
//   The result (red, green, blue) is on rsp_pixel with rsp_strobe high for
//   exactly one cycle. That cycle starts at the edge that loads the sixth stage
//   register, pix6_ff, and the result is taken at the edge that ends it.
//   The six register stages are: clamp and hue*6, partial products,
//   complements, level products, channel select times 255, and rounding.
//   Throughput is one item per cycle.
//   Saturation and brightness above 4096 are treated as 4096. Zero brightness
//   gives black and zero saturation gives grey; both fall out of the same
//   arithmetic with no separate path.
//   Synchronous reset clears all stage valid bits; items in flight are dropped.
//   The receiver cannot stall: each result must be taken in its strobe cycle.
`include "assert_macros.svh"

module hsv_to_rgb_pixel_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  hsv2rgb_pkg::pixel_in_type  req_pixel,
   output logic                       rsp_strobe,
   output hsv2rgb_pkg::pixel_out_type rsp_pixel
);

   localparam int unsigned UW = hsv2rgb_pkg::UNIT_W;
   localparam int unsigned LW = hsv2rgb_pkg::LEVEL_W;
   localparam int unsigned PW = hsv2rgb_pkg::PROD_W;

   logic [hsv2rgb_pkg::LATENCY-1:0] valid_ff;
   logic [hsv2rgb_pkg::LATENCY-1:0] valid_in;
   logic                            accept;

   // stage 1
   logic [UW-1:0] sat1_ff, sat1_in, val1_ff, val1_in;
   logic [2:0]    sector1_ff, sector1_in;
   logic [15:0]   frac1_ff, frac1_in;
   logic [18:0]   scaled;
   // stage 2
   logic [28:0]   sf2_ff, sf2_in, sg2_ff, sg2_in;
   logic [24:0]   pv2_ff, pv2_in;
   logic [UW-1:0] val2_ff;
   logic [2:0]    sector2_ff;
   logic [16:0]   frac_comp;
   // stage 3
   logic [28:0]   qm3_ff, qm3_in, tm3_ff, tm3_in;
   logic [24:0]   pv3_ff;
   logic [UW-1:0] val3_ff;
   logic [2:0]    sector3_ff;
   // stage 4
   logic [LW-1:0] q4_ff, q4_in, t4_ff, t4_in, p4_ff, v4_ff;
   logic [2:0]    sector4_ff;
   // stage 5
   logic [LW-1:0] r_lvl, g_lvl, b_lvl;
   logic [PW-1:0] r5_ff, r5_in, g5_ff, g5_in, b5_ff, b5_in;
   // stage 6
   hsv2rgb_pkg::pixel_out_type pix6_ff, pix6_in;
   logic [PW-1:0] r_sum, g_sum, b_sum;

   function automatic logic [UW-1:0] clamp_unit(input logic [UW-1:0] x);
      return (x > hsv2rgb_pkg::FULL_ONE) ? hsv2rgb_pkg::FULL_ONE : x;
   endfunction

   function automatic logic [PW-1:0] times_255(input logic [LW-1:0] x);
      logic [PW-1:0] wide;
      wide = PW'(x);
      return (wide << 8) - wide;
   endfunction

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      valid_in = {valid_ff[hsv2rgb_pkg::LATENCY-2:0], accept};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // stage 1: clamp, hue*6 into sector and fraction
   always_comb begin
      sat1_in    = clamp_unit(req_pixel.saturation);
      val1_in    = clamp_unit(req_pixel.brightness);
      scaled     = ({3'b0, req_pixel.hue} << 2) + ({3'b0, req_pixel.hue} << 1);
      sector1_in = scaled[18:16];
      frac1_in   = scaled[15:0];
   end

   // stage 2: s*f, s*(1-f), v*(1-s)
   always_comb begin
      frac_comp = 17'h10000 - {1'b0, frac1_ff};
      sf2_in    = 29'(sat1_ff) * 29'(frac1_ff);
      sg2_in    = 29'(sat1_ff) * 29'(frac_comp);
      pv2_in    = 25'(val1_ff) * 25'(hsv2rgb_pkg::FULL_ONE - sat1_ff);
   end

   // stage 3: complements against one
   always_comb begin
      qm3_in = 29'h1000_0000 - sf2_ff;
      tm3_in = 29'h1000_0000 - sg2_ff;
   end

   // stage 4: q and t levels
   always_comb begin
      q4_in = LW'(val3_ff) * LW'(qm3_ff);
      t4_in = LW'(val3_ff) * LW'(tm3_ff);
   end

   // stage 5: channel arrangement by sector, then scale by 255
   always_comb begin
      unique case (sector4_ff)
         3'd0: begin
            r_lvl = v4_ff; g_lvl = t4_ff; b_lvl = p4_ff;
         end
         3'd1: begin
            r_lvl = q4_ff; g_lvl = v4_ff; b_lvl = p4_ff;
         end
         3'd2: begin
            r_lvl = p4_ff; g_lvl = v4_ff; b_lvl = t4_ff;
         end
         3'd3: begin
            r_lvl = p4_ff; g_lvl = q4_ff; b_lvl = v4_ff;
         end
         3'd4: begin
            r_lvl = t4_ff; g_lvl = p4_ff; b_lvl = v4_ff;
         end
         default: begin
            r_lvl = v4_ff; g_lvl = p4_ff; b_lvl = q4_ff;
         end
      endcase
      r5_in = times_255(r_lvl);
      g5_in = times_255(g_lvl);
      b5_in = times_255(b_lvl);
   end

   // stage 6: round half up and take the byte
   always_comb begin
      r_sum = r5_ff + (PW'(1) << 39);
      g_sum = g5_ff + (PW'(1) << 39);
      b_sum = b5_ff + (PW'(1) << 39);
      pix6_in.red   = r_sum[47:40];
      pix6_in.green = g_sum[47:40];
      pix6_in.blue  = b_sum[47:40];
   end

   always_ff @(posedge clock) begin
      sat1_ff    <= sat1_in;
      val1_ff    <= val1_in;
      sector1_ff <= sector1_in;
      frac1_ff   <= frac1_in;

      sf2_ff     <= sf2_in;
      sg2_ff     <= sg2_in;
      pv2_ff     <= pv2_in;
      val2_ff    <= val1_ff;
      sector2_ff <= sector1_ff;

      qm3_ff     <= qm3_in;
      tm3_ff     <= tm3_in;
      pv3_ff     <= pv2_ff;
      val3_ff    <= val2_ff;
      sector3_ff <= sector2_ff;

      q4_ff      <= q4_in;
      t4_ff      <= t4_in;
      p4_ff      <= {pv3_ff, 16'b0};
      v4_ff      <= {val3_ff, 28'b0};
      sector4_ff <= sector3_ff;

      r5_ff      <= r5_in;
      g5_ff      <= g5_in;
      b5_ff      <= b5_in;

      pix6_ff    <= pix6_in;
   end

   assign rsp_strobe = valid_ff[hsv2rgb_pkg::LATENCY-1];
   assign rsp_pixel  = pix6_ff;

   `ASSERT_IMPLIES(a_strobe_has_item, clock, reset, rsp_strobe,
      $past(accept, hsv2rgb_pkg::LATENCY))
   `ASSERT_IMPLIES(a_black_on_zero, clock, reset,
      rsp_strobe && $past(req_pixel.brightness == 13'd0, hsv2rgb_pkg::LATENCY),
      rsp_pixel.red == 8'd0 && rsp_pixel.green == 8'd0 && rsp_pixel.blue == 8'd0)
   `ASSERT_IMPLIES(a_grey_on_zero_sat, clock, reset,
      rsp_strobe && $past(req_pixel.saturation == 13'd0, hsv2rgb_pkg::LATENCY),
      rsp_pixel.red == rsp_pixel.green && rsp_pixel.green == rsp_pixel.blue)

endmodule

[tb/sv/tb_hsv_to_rgb_pixel_unit.sv]
// Self-checking testbench for the HSV to RGB pixel unit.
`timescale 1ns / 1ps

module tb_hsv_to_rgb_pixel_unit;

   localparam int unsigned IDLE_LIMIT = 300;

   typedef enum logic [2:0] {
      SECT_RED_YELLOW,
      SECT_YELLOW_GREEN,
      SECT_GREEN_CYAN,
      SECT_CYAN_BLUE,
      SECT_BLUE_MAGENTA,
      SECT_MAGENTA_RED
   } hue_sector_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   hsv2rgb_pkg::pixel_in_type  req_pixel = '0;
   logic                       rsp_strobe;
   hsv2rgb_pkg::pixel_out_type rsp_pixel;

   hsv2rgb_pkg::pixel_out_type rgb_expected_q[$];
   hsv2rgb_pkg::pixel_out_type rgb_head;
   bit            sender_gaps_on = 1'b0;
   int unsigned   error_count    = 0;
   int unsigned   items_sent     = 0;
   int unsigned   results_seen   = 0;
   int unsigned   black_items    = 0;
   int unsigned   grey_items     = 0;
   int unsigned   clamped_items  = 0;
   int unsigned   quiet_cycles   = 0;

   hsv_to_rgb_pixel_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_pixel  (req_pixel),
      .rsp_strobe (rsp_strobe),
      .rsp_pixel  (rsp_pixel)
   );

   always #5 clock = ~clock;

   // Level in units of 2^-40 to a byte, halves rounding up.
   function automatic logic [7:0] level_byte(input logic [63:0] lvl);
      logic [63:0] r;
      r = (lvl * 64'd255 + (64'd1 << 39)) >> 40;
      return (r > 64'd255) ? 8'd255 : r[7:0];
   endfunction

   function automatic hsv2rgb_pkg::pixel_out_type predict_rgb(
         input hsv2rgb_pkg::pixel_in_type px);
      logic [63:0]                s, v, scaled, frac, lv, lp, lq, lt;
      hue_sector_type             sector;
      hsv2rgb_pkg::pixel_out_type rgb;
      s = (px.saturation > hsv2rgb_pkg::FULL_ONE) ? 64'd4096 : {51'd0, px.saturation};
      v = (px.brightness > hsv2rgb_pkg::FULL_ONE) ? 64'd4096 : {51'd0, px.brightness};
      rgb = '0;
      if (v != 0) begin
         lv = v << 28;
         if (s == 0) begin
            rgb.red   = level_byte(lv);
            rgb.green = rgb.red;
            rgb.blue  = rgb.red;
         end else begin
            scaled = {48'd0, px.hue} * 64'd6;
            sector = hue_sector_type'(scaled[18:16]);
            frac   = {48'd0, scaled[15:0]};
            lp = (v * (64'd4096 - s)) << 16;
            lq = v * ((64'd1 << 28) - s * frac);
            lt = v * ((64'd1 << 28) - s * (64'd65536 - frac));
            unique case (sector)
               SECT_RED_YELLOW: begin
                  rgb = '{level_byte(lv), level_byte(lt), level_byte(lp)};
               end
               SECT_YELLOW_GREEN: begin
                  rgb = '{level_byte(lq), level_byte(lv), level_byte(lp)};
               end
               SECT_GREEN_CYAN: begin
                  rgb = '{level_byte(lp), level_byte(lv), level_byte(lt)};
               end
               SECT_CYAN_BLUE: begin
                  rgb = '{level_byte(lp), level_byte(lq), level_byte(lv)};
               end
               SECT_BLUE_MAGENTA: begin
                  rgb = '{level_byte(lt), level_byte(lp), level_byte(lv)};
               end
               default: begin
                  rgb = '{level_byte(lv), level_byte(lp), level_byte(lq)};
               end
            endcase
         end
      end
      return rgb;
   endfunction

   // Drive one item and hold it until the unit takes it.
   task automatic send_pixel(input logic [15:0] hue, input logic [12:0] sat,
                             input logic [12:0] bri);
      hsv2rgb_pkg::pixel_in_type px;
      int unsigned               gap;
      px.hue        = hue;
      px.saturation = sat;
      px.brightness = bri;
      if (sender_gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 9);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start     <= 1'b1;
      req_pixel <= px;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      rgb_expected_q.push_back(predict_rgb(px));
      items_sent++;
      if (bri == 0) black_items++;
      else if (sat == 0) grey_items++;
      if (sat > hsv2rgb_pkg::FULL_ONE || bri > hsv2rgb_pkg::FULL_ONE) clamped_items++;
   endtask

   function automatic logic [12:0] rand_unit();
      unique case ($urandom_range(0, 9))
         0:       return 13'd0;
         1:       return hsv2rgb_pkg::FULL_ONE;
         2:       return 13'($urandom_range(4097, 8191));
         3:       return 13'($urandom_range(1, 15));
         4:       return 13'($urandom & 32'h1fff);
         default: return 13'($urandom_range(0, 4096));
      endcase
   endfunction

   task automatic test_extremes();
      send_pixel(16'd0,     hsv2rgb_pkg::FULL_ONE, hsv2rgb_pkg::FULL_ONE);
      send_pixel(16'hffff,  13'h1fff, 13'h1fff);
      send_pixel(16'hffff,  hsv2rgb_pkg::FULL_ONE, hsv2rgb_pkg::FULL_ONE);
      send_pixel(16'd1,     13'd1,    13'd1);
      send_pixel(16'h8000,  13'd4097, 13'd4097);
   endtask

   task automatic test_black_and_grey();
      send_pixel(16'd0,     13'd0,    13'd0);
      send_pixel(16'd12345, hsv2rgb_pkg::FULL_ONE, 13'd0);
      send_pixel(16'hffff,  13'h1fff, 13'd0);
      send_pixel(16'd4000,  13'd0,    hsv2rgb_pkg::FULL_ONE);
      send_pixel(16'd50000, 13'd0,    13'd2048);
      send_pixel(16'd7,     13'd0,    13'd1);
      send_pixel(16'd30000, 13'd0,    13'h1fff);
   endtask

   // Hues on both sides of each of the five inner sector boundaries.
   task automatic test_sector_edges();
      logic [15:0] edge_hue;
      for (int k = 1; k < 6; k++) begin
         edge_hue = 16'((k * 65536 + 5) / 6);
         send_pixel(edge_hue - 16'd1, hsv2rgb_pkg::FULL_ONE, hsv2rgb_pkg::FULL_ONE);
         send_pixel(edge_hue,         13'd3000, hsv2rgb_pkg::FULL_ONE);
      end
   endtask

   task automatic test_random_colors(input int unsigned count);
      for (int unsigned i = 0; i < count; i++) begin
         if (i % 40 == 0) sender_gaps_on = ($urandom_range(0, 2) != 0);
         send_pixel(16'($urandom), rand_unit(), rand_unit());
      end
   endtask

   task automatic test_back_to_back(input int unsigned count);
      sender_gaps_on = 1'b0;
      for (int unsigned i = 0; i < count; i++)
         send_pixel(16'($urandom), rand_unit(), rand_unit());
      start <= 1'b0;
   endtask

   task automatic check_channel(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // Results sampled mid-cycle; the strobe is held for the whole cycle.
   always @(negedge clock) begin
      if (!reset && rsp_strobe) begin
         results_seen++;
         if (rgb_expected_q.size() == 0) begin
            $display("%0t: unexpected result expected none actual %h", $time, rsp_pixel);
            error_count++;
         end else begin
            rgb_head = rgb_expected_q.pop_front();
            check_channel("red",   rgb_head.red,   rsp_pixel.red);
            check_channel("green", rgb_head.green, rsp_pixel.green);
            check_channel("blue",  rgb_head.blue,  rsp_pixel.blue);
         end
      end
   end

   always @(negedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout with %0d items outstanding", $time,
                     rgb_expected_q.size());
            $display("hsv_to_rgb_pixel_unit: mismatch");
            $finish;
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_extremes();
      test_black_and_grey();
      test_sector_edges();
      test_random_colors(1030);
      test_back_to_back(200);
      while (rgb_expected_q.size() != 0) @(posedge clock);
      repeat (hsv2rgb_pkg::LATENCY + 4) @(posedge clock);
      $display("Converted %0d colors, checked %0d results across all six hue sectors.",
               items_sent, results_seen);
      $display("Included %0d black, %0d grey and %0d clamped-input items.",
               black_items, grey_items, clamped_items);
      if (error_count == 0)
         $display("hsv_to_rgb_pixel_unit: match");
      else
         $display("hsv_to_rgb_pixel_unit: mismatch");
      $finish;
   end

endmodule
